// ----- design/pbs_pkg.sv -----
// Package for the pooling backward scatter block.
// Holds field widths, register indexes, the front state type and the job record.
// No dependencies.
package pbs_pkg;

    localparam int PX_W    = 10;
    localparam int COORD_W = 13;
    localparam int PLANE_W = 16;
    localparam int GRAD_W  = 32;
    localparam int SLOT_W  = 6;
    localparam int SIDE_W  = 4;
    localparam int AREA_W  = 7;

    // radix-256 divider: eight quotient bits per cycle
    localparam int DIGIT_BITS = 8;
    localparam int DIV_STEPS  = GRAD_W / DIGIT_BITS;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_POOL_MODE   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIDE = 1'b1;

    localparam logic MODE_MAX  = 1'b0;
    localparam logic MODE_MEAN = 1'b1;

    typedef enum logic [1:0] {
        F_EMPTY,
        F_DIVIDE,
        F_HOLD
    } front_state_t;

    // one classified window, as it travels from front to back
    typedef struct packed {
        logic [COORD_W-1:0] base_x;
        logic [COORD_W-1:0] base_y;
        logic [PLANE_W-1:0] plane;
        logic [GRAD_W-1:0]  value;
        logic               mean;
        logic               bad;
        logic [SLOT_W-1:0]  slot;
        logic [SIDE_W-1:0]  side;
    } scatter_job_t;

endpackage

// ----- design/pooling_backward_scatter.sv -----
// Path: an input transaction is registered in the front, pushed into the job queue and then
// loaded into the output register; in mean mode it first passes through the radix-256 divider.
// Throughput: one result per cycle while the receiver is ready; an item gives side*side results.
// Front: one item per cycle in max mode while the queue has room, in mean mode a new item
// only after the divide ends; a 4-entry job queue lets the two sides stall independently.
// Reset (rst_n, async, active low): pool_mode 0, window_side 2, queue and output empty.
module pooling_backward_scatter
    import pbs_pkg::*;
#(
    parameter int MAX_WINDOW      = 8,
    parameter int MAX_POOLED_SIDE = 1024
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration write channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    // input channel
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [PX_W-1:0]          pooled_x,
    input  logic [PX_W-1:0]          pooled_y,
    input  logic [PLANE_W-1:0]       plane_tag,
    input  logic signed [GRAD_W-1:0] grad_value,
    input  logic [SLOT_W-1:0]        argmax_slot,
    // result channel
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [COORD_W-1:0]       source_x,
    output logic [COORD_W-1:0]       source_y,
    output logic [PLANE_W-1:0]       plane_out,
    output logic signed [GRAD_W-1:0] grad_out,
    output logic                     bad_slot,
    output logic                     last_of_window
);

    logic               pool_mode_reg, pool_mode_next;
    logic [SIDE_W-1:0]  window_side_reg, window_side_next;
    logic               cfg_write;

    logic               q_push, q_pop, q_empty, q_full;
    scatter_job_t       q_in, q_head;
    logic [GRAD_W-1:0]  grad_bits;

    // The configuration port never stalls: take every write transaction at once.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // Decode the register index; each write replaces the whole register.
    always_comb
    begin
        pool_mode_next   = pool_mode_reg;
        window_side_next = window_side_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                CFG_POOL_MODE:   pool_mode_next   = cfg_data[0];
                CFG_WINDOW_SIDE: window_side_next = cfg_data;
                default:         pool_mode_next   = pool_mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_mode_reg   <= MODE_MAX;
            window_side_reg <= SIDE_W'(2);
        end
        else
        begin
            pool_mode_reg   <= pool_mode_next;
            window_side_reg <= window_side_next;
        end
    end

    // Front: accept a transaction, clamp side and coordinates, flag a bad argmax
    // slot, and divide the gradient by the window area in mean mode.
    pbs_front #(
        .MAX_WINDOW      (MAX_WINDOW),
        .MAX_POOLED_SIDE (MAX_POOLED_SIDE)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pooled_x    (pooled_x),
        .pooled_y    (pooled_y),
        .plane_tag   (plane_tag),
        .grad_value  (grad_value),
        .argmax_slot (argmax_slot),
        .pool_mode   (pool_mode_reg),
        .window_side (window_side_reg),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    // Hold classified windows until the back is free.
    pbs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: advance through the window at the queue head, one result per cycle while
    // the output is not stalled, and drop the job on its last result.
    pbs_back #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .source_x       (source_x),
        .source_y       (source_y),
        .plane_out      (plane_out),
        .grad_out       (grad_bits),
        .bad_slot       (bad_slot),
        .last_of_window (last_of_window)
    );

    assign grad_out = grad_bits;

endmodule

// ----- design/pbs_front.sv -----
// Front part: accepts input transactions, clamps and classifies them, and
// runs the mean share through a radix-256 divider. Depends on pbs_pkg.
module pbs_front
    import pbs_pkg::*;
#(
    parameter int MAX_WINDOW      = 8,
    parameter int MAX_POOLED_SIDE = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [PX_W-1:0]      pooled_x,
    input  logic [PX_W-1:0]      pooled_y,
    input  logic [PLANE_W-1:0]   plane_tag,
    input  logic [GRAD_W-1:0]    grad_value,
    input  logic [SLOT_W-1:0]    argmax_slot,
    input  logic                 pool_mode,
    input  logic [SIDE_W-1:0]    window_side,
    input  logic                 q_full,
    output logic                 q_push,
    output scatter_job_t         q_data
);

    front_state_t        st_reg, st_next;
    scatter_job_t        job_reg, job_next;
    logic [GRAD_W-1:0]   work_reg, work_next;
    logic [AREA_W-1:0]   rem_reg, rem_next;
    logic [AREA_W-1:0]   area_reg, area_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                neg_reg, neg_next;

    logic                accept;
    logic [SIDE_W-1:0]   side_eff;
    logic [AREA_W-1:0]   area_in;
    logic [PX_W-1:0]     px_c, py_c;
    logic [GRAD_W-1:0]   div_work;
    logic [AREA_W-1:0]   div_rem;
    logic [AREA_W:0]     trial;

    // clamp the side and the pooled coordinates
    always_comb
    begin
        if (window_side == '0)
            side_eff = SIDE_W'(1);
        else if (32'(window_side) > MAX_WINDOW)
            side_eff = SIDE_W'(MAX_WINDOW);
        else
            side_eff = window_side;
        area_in = AREA_W'(side_eff) * AREA_W'(side_eff);
        px_c = (32'(pooled_x) >= MAX_POOLED_SIDE) ? PX_W'(MAX_POOLED_SIDE - 1) : pooled_x;
        py_c = (32'(pooled_y) >= MAX_POOLED_SIDE) ? PX_W'(MAX_POOLED_SIDE - 1) : pooled_y;
    end

    // one radix-256 digit: eight restoring steps on a remainder below the area
    always_comb
    begin
        div_work = work_reg;
        div_rem  = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial    = {div_rem, div_work[GRAD_W-1]};
            div_work = {div_work[GRAD_W-2:0], 1'b0};
            if (trial >= {1'b0, area_reg})
            begin
                trial       = trial - {1'b0, area_reg};
                div_work[0] = 1'b1;
            end
            div_rem = trial[AREA_W-1:0];
        end
    end

    assign q_push   = (st_reg == F_HOLD) && !q_full;
    assign in_ready = (st_reg == F_EMPTY) || q_push;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        q_data       = job_reg;
        q_data.value = neg_reg ? (GRAD_W'(0) - work_reg) : work_reg;
    end

    always_comb
    begin
        st_next   = st_reg;
        job_next  = job_reg;
        work_next = work_reg;
        rem_next  = rem_reg;
        area_next = area_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        case (st_reg)
            F_DIVIDE:
            begin
                work_next = div_work;
                rem_next  = div_rem;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                    st_next = F_HOLD;
            end
            F_HOLD:
            begin
                if (q_push)
                    st_next = F_EMPTY;
            end
            F_EMPTY:
            begin
                st_next = F_EMPTY;
            end
            default:
            begin
                st_next = F_EMPTY;
            end
        endcase
        if (accept)
        begin
            job_next.base_x = COORD_W'(px_c) * COORD_W'(side_eff);
            job_next.base_y = COORD_W'(py_c) * COORD_W'(side_eff);
            job_next.plane  = plane_tag;
            job_next.value  = '0;
            job_next.mean   = pool_mode;
            job_next.bad    = (pool_mode == MODE_MAX) && (AREA_W'(argmax_slot) >= area_in);
            job_next.slot   = argmax_slot;
            job_next.side   = side_eff;
            area_next       = area_in;
            rem_next        = '0;
            step_next       = '0;
            if (pool_mode == MODE_MEAN)
            begin
                neg_next  = grad_value[GRAD_W-1];
                work_next = grad_value[GRAD_W-1] ? (GRAD_W'(0) - grad_value) : grad_value;
                st_next   = F_DIVIDE;
            end
            else
            begin
                neg_next  = 1'b0;
                work_next = grad_value;
                st_next   = F_HOLD;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= F_EMPTY;
            step_reg <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        work_reg <= work_next;
        rem_reg  <= rem_next;
        area_reg <= area_next;
        neg_reg  <= neg_next;
    end

endmodule

// ----- design/pbs_queue.sv -----
// Short job queue between front and back, built from flip-flops.
// Depends on pbs_pkg.
module pbs_queue
    import pbs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  scatter_job_t push_data,
    input  logic         pop,
    output scatter_job_t head,
    output logic         empty,
    output logic         full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    scatter_job_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, wr_next;
    logic [PTR_W-1:0]   rd_reg, rd_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? PTR_W'((32'(wr_reg) + 1) % QUEUE_DEPTH) : wr_reg;
        rd_next  = pop  ? PTR_W'((32'(rd_reg) + 1) % QUEUE_DEPTH) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full && !pop |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue pop while empty");

endmodule

// ----- design/pbs_back.sv -----
// Back part: walks the window of the job at the queue head in row-major
// order and drives the registered result channel. Depends on pbs_pkg.
module pbs_back
    import pbs_pkg::*;
#(
    parameter int MAX_WINDOW = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  scatter_job_t         head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [COORD_W-1:0]   source_x,
    output logic [COORD_W-1:0]   source_y,
    output logic [PLANE_W-1:0]   plane_out,
    output logic [GRAD_W-1:0]    grad_out,
    output logic                 bad_slot,
    output logic                 last_of_window
);

    localparam int CW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [CW-1:0]       cx_reg, cx_next;
    logic [CW-1:0]       cy_reg, cy_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic                ov_reg, ov_next;
    logic [COORD_W-1:0]  sx_reg, sy_reg;
    logic [PLANE_W-1:0]  pl_reg;
    logic [GRAD_W-1:0]   g_reg;
    logic                bad_reg, last_reg;

    logic                advance, emit, row_end, win_end;
    logic [GRAD_W-1:0]   g_now;

    assign advance = !ov_reg || out_ready;
    assign emit    = advance && !q_empty;
    assign row_end = (SIDE_W'(cx_reg) == head.side - SIDE_W'(1));
    assign win_end = row_end && (SIDE_W'(cy_reg) == head.side - SIDE_W'(1));
    assign q_pop   = emit && win_end;

    always_comb
    begin
        if (head.mean)
            g_now = head.value;
        else if (!head.bad && (pos_reg == head.slot))
            g_now = head.value;
        else
            g_now = '0;
    end

    always_comb
    begin
        cx_next  = cx_reg;
        cy_next  = cy_reg;
        pos_next = pos_reg;
        ov_next  = ov_reg;
        if (advance)
            ov_next = !q_empty;
        if (emit)
        begin
            if (win_end)
            begin
                cx_next  = '0;
                cy_next  = '0;
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + SLOT_W'(1);
                if (row_end)
                begin
                    cx_next = '0;
                    cy_next = cy_reg + CW'(1);
                end
                else
                begin
                    cx_next = cx_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg  <= '0;
            cy_reg  <= '0;
            pos_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            pos_reg <= pos_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            sx_reg   <= head.base_x + COORD_W'(cx_reg);
            sy_reg   <= head.base_y + COORD_W'(cy_reg);
            pl_reg   <= head.plane;
            g_reg    <= g_now;
            bad_reg  <= head.bad;
            last_reg <= win_end;
        end
    end

    assign out_valid      = ov_reg;
    assign source_x       = sx_reg;
    assign source_y       = sy_reg;
    assign plane_out      = pl_reg;
    assign grad_out       = g_reg;
    assign bad_slot       = bad_reg;
    assign last_of_window = last_reg;

    a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && bad_reg |-> g_reg == '0)
        else $error("bad slot result carries a nonzero gradient");

    a_walk_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        !q_empty |-> (SIDE_W'(cx_reg) < head.side) && (SIDE_W'(cy_reg) < head.side))
        else $error("window walk left the window");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the pooling backward scatter block.
// Drives items and register writes, predicts every result and compares each field.
// Depends on pbs_pkg and pooling_backward_scatter from the design folder.
module testbench;
    import pbs_pkg::*;

    localparam int WINDOW_CAP   = 8;
    localparam int HALF_PERIOD  = 4;
    localparam int RESET_CYCLES = 8;
    // Mean mode also passes through the divider before the output register; leave margin.
    localparam int SETTLE       = 16;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 36;
    // Bound on the run: ~400 items, 64 results each, each result slowed by receiver stalls.
    localparam int CYCLE_LIMIT  = 1000000;

    typedef struct {
        logic [PX_W-1:0]          px;
        logic [PX_W-1:0]          py;
        logic [PLANE_W-1:0]       plane;
        logic signed [GRAD_W-1:0] grad;
        logic [SLOT_W-1:0]        slot;
    } item_t;

    typedef struct {
        logic [COORD_W-1:0]       sx;
        logic [COORD_W-1:0]       sy;
        logic [PLANE_W-1:0]       plane;
        logic signed [GRAD_W-1:0] grad;
        logic                     bad;
        logic                     last;
    } result_t;

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

    // One line of the directed table: an item or a register write, with an
    // optional hand-typed first result of the window.
    typedef struct {
        row_kind_t                kind;
        logic [CFG_INDEX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]    reg_data;
        item_t                    it;
        bit                       typed;
        logic [COORD_W-1:0]       ex;
        logic [COORD_W-1:0]       ey;
        logic [GRAD_W-1:0]        egrad;
        logic                     ebad;
    } row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic [PX_W-1:0]          pooled_x;
    logic [PX_W-1:0]          pooled_y;
    logic [PLANE_W-1:0]       plane_tag;
    logic signed [GRAD_W-1:0] grad_value;
    logic [SLOT_W-1:0]        argmax_slot;
    logic                     out_valid;
    logic                     out_ready;
    logic [COORD_W-1:0]       source_x;
    logic [COORD_W-1:0]       source_y;
    logic [PLANE_W-1:0]       plane_out;
    logic signed [GRAD_W-1:0] grad_out;
    logic                     bad_slot;
    logic                     last_of_window;

    // Shadow copy of the two registers, updated on each accepted write.
    logic                     shadow_mode;
    logic [CFG_DATA_W-1:0]    shadow_side;

    result_t pending_results[$];
    row_t    plan[$];

    int  failures;
    int  items_sent;
    int  directed_items;
    int  results_seen;
    int  reg_writes;
    int  cycle_count;
    bit  idle_on;

    pooling_backward_scatter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .pooled_x       (pooled_x),
        .pooled_y       (pooled_y),
        .plane_tag      (plane_tag),
        .grad_value     (grad_value),
        .argmax_slot    (argmax_slot),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .source_x       (source_x),
        .source_y       (source_y),
        .plane_out      (plane_out),
        .grad_out       (grad_out),
        .bad_slot       (bad_slot),
        .last_of_window (last_of_window)
    );

    always
    begin
        clk = 1'b1;
        #HALF_PERIOD;
        clk = 1'b0;
        #HALF_PERIOD;
    end

    // Watchdog: end the run once cycle_count passes CYCLE_LIMIT, in case the block stops making progress.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, pending_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Side zero acts as one, anything past the cap saturates to the cap.
    function automatic int eff_side(logic [CFG_DATA_W-1:0] raw);
        int s;
        s = raw;
        if (s == 0)
            s = 1;
        if (s > WINDOW_CAP)
            s = WINDOW_CAP;
        return s;
    endfunction

    // Compute every result of one window and queue it. Pooled coordinates are
    // 10 bits wide, so the clamp to the pooled side never takes effect.
    function automatic result_t scatter_window(item_t it);
        int                       side;
        int                       area;
        int                       pos;
        logic                     bad;
        logic signed [GRAD_W-1:0] share;
        result_t                  r;
        result_t                  head;
        side  = eff_side(shadow_side);
        area  = side * side;
        bad   = (shadow_mode == MODE_MAX) && (int'(it.slot) >= area);
        share = '0;
        if (shadow_mode == MODE_MEAN)
            share = GRAD_W'(longint'(it.grad) / longint'(area));
        for (int cy = 0; cy < side; cy++)
        begin
            for (int cx = 0; cx < side; cx++)
            begin
                pos     = cy * side + cx;
                r.sx    = COORD_W'(int'(it.px) * side + cx);
                r.sy    = COORD_W'(int'(it.py) * side + cy);
                r.plane = it.plane;
                if (shadow_mode == MODE_MEAN)
                    r.grad = share;
                else
                    r.grad = (!bad && pos == int'(it.slot)) ? it.grad : '0;
                r.bad   = bad;
                r.last  = (pos + 1 == area);
                if (pos == 0)
                    head = r;
                pending_results.push_back(r);
            end
        end
        return head;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    area;
        area     = eff_side(shadow_side) * eff_side(shadow_side);
        it.px    = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                               : PX_W'($urandom);
        it.py    = ($urandom_range(0, 5) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
                                               : PX_W'($urandom);
        it.plane = PLANE_W'($urandom);
        case ($urandom_range(0, 9))
            0:       it.grad = 32'sh8000_0000;
            1:       it.grad = 32'sh7FFF_FFFF;
            2:       it.grad = -32'sd1;
            3:       it.grad = GRAD_W'($signed($urandom_range(0, 511)) - 256);
            default: it.grad = GRAD_W'($urandom);
        endcase
        // Mostly a slot inside the window; the rest is any 6-bit slot.
        if ($urandom_range(0, 4) != 0)
            it.slot = SLOT_W'($urandom_range(0, area - 1));
        else
            it.slot = SLOT_W'($urandom);
        return it;
    endfunction

    function automatic row_t item_row(int px, int py, int plane, logic [31:0] grad,
                                      int slot);
        row_t r;
        r.kind      = ROW_ITEM;
        r.reg_index = '0;
        r.reg_data  = '0;
        r.it.px     = PX_W'(px);
        r.it.py     = PX_W'(py);
        r.it.plane  = PLANE_W'(plane);
        r.it.grad   = grad;
        r.it.slot   = SLOT_W'(slot);
        r.typed     = 1'b0;
        r.ex        = '0;
        r.ey        = '0;
        r.egrad     = '0;
        r.ebad      = 1'b0;
        return r;
    endfunction

    function automatic row_t typed_row(int px, int py, int plane, logic [31:0] grad,
                                       int slot, int ex, int ey, logic [31:0] egrad,
                                       logic ebad);
        row_t r;
        r       = item_row(px, py, plane, grad, slot);
        r.typed = 1'b1;
        r.ex    = COORD_W'(ex);
        r.ey    = COORD_W'(ey);
        r.egrad = egrad;
        r.ebad  = ebad;
        return r;
    endfunction

    function automatic row_t cfg_row(logic [CFG_INDEX_W-1:0] idx,
                                     logic [CFG_DATA_W-1:0] data);
        row_t r;
        r           = item_row(0, 0, 0, 32'h0, 0);
        r.kind      = ROW_CFG;
        r.reg_index = idx;
        r.reg_data  = data;
        return r;
    endfunction

    task automatic report(input string what, input logic [31:0] want,
                          input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
        failures++;
    endtask

    // Receiver: draw a stall for every result, then take and check it.
    initial
    begin : receiver
        int      stall;
        result_t e;
        stall     = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                stall--;
            end
            else
            begin
                out_ready <= 1'b1;
            end
            @(posedge clk);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                begin
                    $display("%0t: result with nothing expected, x %h y %h grad %h",
                             $time, source_x, source_y, grad_out);
                    failures++;
                end
                else
                begin
                    e = pending_results.pop_front();
                    if (source_x !== e.sx)
                        report("source_x", 32'(e.sx), 32'(source_x));
                    if (source_y !== e.sy)
                        report("source_y", 32'(e.sy), 32'(source_y));
                    if (plane_out !== e.plane)
                        report("plane_out", 32'(e.plane), 32'(plane_out));
                    if (grad_out !== e.grad)
                        report("grad_out", e.grad, grad_out);
                    if (bad_slot !== e.bad)
                        report("bad_slot", 32'(e.bad), 32'(bad_slot));
                    if (last_of_window !== e.last)
                        report("last_of_window", 32'(e.last), 32'(last_of_window));
                end
                stall = idle_on ? $urandom_range(0, 8) : 0;
            end
        end
    end

    // Entered just after a falling edge. Hold valid across back-to-back items
    // so it gets a single assignment per step; drop it only for a real gap.
    task automatic send_item(input item_t it, output result_t head);
        int gap;
        gap = idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pooled_x    <= it.px;
        pooled_y    <= it.py;
        plane_tag   <= it.plane;
        grad_value  <= it.grad;
        argmax_slot <= it.slot;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        head = scatter_window(it);
        items_sent++;
        @(negedge clk);
    endtask

    // Entered just after a falling edge with no item pending on the input.
    // Leave cfg_valid high so a following write can reuse it; the caller drops it.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        if (idx == CFG_POOL_MODE)
            shadow_mode = data[0];
        else if (idx == CFG_WINDOW_SIDE)
            shadow_side = data;
        reg_writes++;
        @(negedge clk);
    endtask

    // Drop the input valid and wait until every queued result has come back,
    // then let the pipeline settle before any register changes.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    initial
    begin : stimulus
        result_t head;
        item_t   it;
        int      phase_sides[RANDOM_PHASES];
        int      side_pick;

        failures       = 0;
        items_sent     = 0;
        results_seen   = 0;
        reg_writes     = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;
        shadow_mode    = MODE_MAX;
        shadow_side    = 4'd2;

        // Hold every input at a known value from time zero.
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        pooled_x    = '0;
        pooled_y    = '0;
        plane_tag   = '0;
        grad_value  = '0;
        argmax_slot = '0;

        // Directed table. Rows start at reset settings: max mode, side 2.
        plan.push_back(typed_row(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 32'h7FFF_FFFF, 0));
        plan.push_back(typed_row(1023, 1023, 16'hFFFF, 32'h8000_0000, 3,
                                 2046, 2046, 32'h0, 0));
        // argmax just past the window flags every result
        plan.push_back(typed_row(5, 7, 16'h1234, 32'h0001_0000, 4, 10, 14, 32'h0, 1));
        plan.push_back(typed_row(0, 0, 16'hAAAA, 32'hFFFF_FFFF, 63, 0, 0, 32'h0, 1));
        plan.push_back(item_row(512, 341, 16'h5555, 32'h5555_5555, 2));
        // side zero acts as side one
        plan.push_back(cfg_row(CFG_WINDOW_SIDE, 4'd0));
        plan.push_back(typed_row(1023, 0, 1, 32'h0001_2345, 0, 1023, 0, 32'h0001_2345, 0));
        plan.push_back(typed_row(0, 1023, 2, 32'h0001_2345, 1, 0, 1023, 32'h0, 1));
        // side fifteen saturates to the cap
        plan.push_back(cfg_row(CFG_WINDOW_SIDE, 4'd15));
        plan.push_back(typed_row(1023, 1023, 3, 32'hFFFF_FFFF, 63, 8184, 8184, 32'h0, 0));
        plan.push_back(typed_row(1, 2, 4, 32'h4000_0000, 0, 8, 16, 32'h4000_0000, 0));
        plan.push_back(item_row(100, 200, 5, 32'h0BAD_F00D, 37));
        // mean mode at the largest window; slot is ignored
        plan.push_back(cfg_row(CFG_POOL_MODE, 4'h1));
        plan.push_back(typed_row(7, 7, 6, 32'h8000_0000, 63, 56, 56, 32'hFE00_0000, 0));
        plan.push_back(typed_row(0, 0, 7, 32'h7FFF_FFFF, 0, 0, 0, 32'h01FF_FFFF, 0));
        // truncation toward zero
        plan.push_back(typed_row(0, 0, 8, 32'hFFFF_FFFF, 0, 0, 0, 32'h0, 0));
        plan.push_back(cfg_row(CFG_WINDOW_SIDE, 4'd3));
        plan.push_back(typed_row(2, 1, 9, 32'd100, 9, 6, 3, 32'd11, 0));
        plan.push_back(typed_row(2, 1, 10, 32'hFFFF_FF9C, 0, 6, 3, 32'hFFFF_FFF5, 0));
        plan.push_back(cfg_row(CFG_WINDOW_SIDE, 4'd1));
        plan.push_back(typed_row(1023, 1023, 11, 32'h8000_0000, 50,
                                 1023, 1023, 32'h8000_0000, 0));
        // only bit 0 of the mode write counts: 4'hE selects max mode
        plan.push_back(cfg_row(CFG_POOL_MODE, 4'hE));
        plan.push_back(typed_row(3, 4, 12, 32'h0002_0000, 2, 3, 4, 32'h0, 1));
        plan.push_back(typed_row(3, 4, 13, 32'h0002_0000, 0, 3, 4, 32'h0002_0000, 0));
        plan.push_back(cfg_row(CFG_POOL_MODE, 4'hF));
        plan.push_back(cfg_row(CFG_WINDOW_SIDE, 4'd7));
        plan.push_back(item_row(300, 400, 14, 32'h1357_9BDF, 0));
        plan.push_back(item_row(1023, 1023, 16'hFFFF, 32'hEDCB_A987, 11));
        plan.push_back(cfg_row(CFG_WINDOW_SIDE, 4'd9));
        plan.push_back(typed_row(1, 1, 15, 32'h0000_0040, 0, 8, 8, 32'd1, 0));
        plan.push_back(cfg_row(CFG_POOL_MODE, 4'h0));
        plan.push_back(typed_row(0, 0, 16, 32'h1234_5678, 8, 0, 0, 32'h0, 0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the table. Drain before the first write of a group of writes.
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (i == 0 || plan[i-1].kind == ROW_ITEM)
                    drain();
                write_reg(plan[i].reg_index, plan[i].reg_data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_item(plan[i].it, head);
                if (plan[i].typed)
                begin
                    if (head.sx !== plan[i].ex)
                        report("table source_x", 32'(plan[i].ex), 32'(head.sx));
                    if (head.sy !== plan[i].ey)
                        report("table source_y", 32'(plan[i].ey), 32'(head.sy));
                    if (head.grad !== plan[i].egrad)
                        report("table grad_out", plan[i].egrad, head.grad);
                    if (head.bad !== plan[i].ebad)
                        report("table bad_slot", 32'(plan[i].ebad), 32'(head.bad));
                end
            end
        end
        directed_items = items_sent;

        // Random phases: small windows dominate, the extremes appear once each.
        phase_sides = '{1, 2, 3, 2, 4, 8, 0, 15, 5, -1};
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            drain();
            side_pick = (phase_sides[p] < 0) ? $urandom_range(0, 15) : phase_sides[p];
            write_reg(CFG_POOL_MODE, CFG_DATA_W'($urandom));
            write_reg(CFG_WINDOW_SIDE, CFG_DATA_W'(side_pick));
            cfg_valid <= 1'b0;
            // every fourth phase runs flat out on both sides
            idle_on = (p % 4 != 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // pause the sender mid-phase until the output has caught up
                if (n == PHASE_ITEMS / 2)
                    drain();
                it = random_item();
                send_item(it, head);
            end
        end

        in_valid <= 1'b0;
        idle_on = 1'b1;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d items (%0d from the table) under %0d register writes;",
                 items_sent, directed_items, reg_writes);
        $display("checked %0d scattered results in max and mean mode, sides 0 to 15.",
                 results_seen);
        if (failures == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- pooling_backward_scatter.f -----
design/pbs_pkg.sv
design/pbs_front.sv
design/pbs_queue.sv
design/pbs_back.sv
design/pooling_backward_scatter.sv
dv/testbench.sv
